// ===== rtl/nmt_pkg.sv =====
// Shared definitions for the neighbor metric table: operation codes, result
// codes, stream field widths and the command/status structs between blocks.
// No dependencies.
package nmt_pkg;

   localparam int MAX_ENTRIES_DEF = 16;

   localparam int REQ_TDATA_W = 232;
   localparam int REQ_TUSER_W = 6;
   localparam int RSP_TDATA_W = 160;
   localparam int RSP_TUSER_W = 2;

   localparam int KEY_W = 128;
   localparam int MET_W = 96;

   localparam logic [2:0] KIND_INSERT      = 3'd0;
   localparam logic [2:0] KIND_READ_ADDR   = 3'd1;
   localparam logic [2:0] KIND_READ_METRIC = 3'd2;
   localparam logic [2:0] KIND_EXISTS      = 3'd3;
   localparam logic [2:0] KIND_UPD_LL      = 3'd4;
   localparam logic [2:0] KIND_UPD_THR     = 3'd5;

   localparam logic [2:0] SEL_LATENCY    = 3'd2;
   localparam logic [2:0] SEL_LOSS       = 3'd3;
   localparam logic [2:0] SEL_THROUGHPUT = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_MISS = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   localparam logic [2:0] RES_OK     = 3'd0;
   localparam logic [2:0] RES_MISS   = 3'd1;
   localparam logic [2:0] RES_FULL   = 3'd2;
   localparam logic [2:0] RES_ADDR   = 3'd3;
   localparam logic [2:0] RES_METRIC = 3'd4;

   typedef struct packed {
      logic       capture;
      logic       ins_wr;
      logic       upd_wr;
      logic       scan_load;
      logic       scan_dec;
      logic       res_load;
      logic [2:0] res_code;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic [2:0] kind;
      logic       full;
      logic       empty;
      logic       pos_ok;
      logic       match;
      logic       scan_zero;
      logic       out_free;
   } sts_type;

endpackage

// ===== rtl/nmt_dp.sv =====
// Datapath of the neighbor metric table: transaction capture, entry memories,
// scan index, match compare, result and output registers.
// Depends on nmt_pkg.
module nmt_dp #(
   parameter int MAX_ENTRIES = nmt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [nmt_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [nmt_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  nmt_pkg::cmd_type                cmd,
   output nmt_pkg::sts_type                sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [nmt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [nmt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int PCW   = (CNT_W > 8) ? CNT_W : 8;

   logic [2:0]                  kind_ff;
   logic [2:0]                  sel_ff;
   logic [nmt_pkg::KEY_W-1:0]   key_ff;
   logic [nmt_pkg::MET_W-1:0]   met_ff;
   logic [7:0]                  pos_ff;
   logic [CNT_W-1:0]            count_ff;
   logic [CNT_W-1:0]            count_in;
   logic [IDX_W-1:0]            scan_ff;
   logic [IDX_W-1:0]            scan_in;
   logic [nmt_pkg::KEY_W-1:0]   key_mem [MAX_ENTRIES];
   logic [nmt_pkg::MET_W-1:0]   met_mem [MAX_ENTRIES];
   logic [nmt_pkg::KEY_W-1:0]   rd_key_ff;
   logic [nmt_pkg::MET_W-1:0]   rd_met_ff;
   logic [IDX_W-1:0]            rd_addr;
   logic [IDX_W-1:0]            wr_addr;
   logic [nmt_pkg::MET_W-1:0]   met_wdata;
   logic [IDX_W-1:0]            last_idx;
   logic [IDX_W-1:0]            pos_slot;
   logic [7:0]                  pos_eff;
   logic [1:0]                  res_status_ff;
   logic [1:0]                  res_status_in;
   logic [31:0]                 res_value_ff;
   logic [31:0]                 res_value_in;
   logic [nmt_pkg::KEY_W-1:0]   res_addr_ff;
   logic [nmt_pkg::KEY_W-1:0]   res_addr_in;
   logic                        out_valid_ff;
   logic                        out_valid_in;
   logic [nmt_pkg::RSP_TDATA_W-1:0] out_data_ff;
   logic [nmt_pkg::RSP_TUSER_W-1:0] out_user_ff;

   // Metric words hold latency in the low bits, then loss, then throughput.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff <= req_tuser[2:0];
         sel_ff  <= req_tuser[5:3];
         key_ff  <= req_tdata[127:0];
         met_ff  <= req_tdata[223:128];
         pos_ff  <= req_tdata[231:224];
      end
   end

   assign pos_eff  = (pos_ff == 8'd0) ? 8'd1 : pos_ff;
   assign pos_slot = IDX_W'(PCW'(count_ff) - PCW'(pos_eff));
   assign last_idx = IDX_W'(count_ff - CNT_W'(1));

   always_comb begin
      count_in = count_ff;
      if (cmd.ins_wr) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      scan_in = scan_ff;
      if (cmd.scan_load) begin
         scan_in = last_idx;
      end else if (cmd.scan_dec) begin
         scan_in = scan_ff - IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in;
   end

   always_comb begin
      if (cmd.scan_load || cmd.scan_dec) begin
         rd_addr = scan_in;
      end else begin
         rd_addr = pos_slot;
      end
   end

   assign wr_addr = cmd.ins_wr ? count_ff[IDX_W-1:0] : scan_ff;

   always_comb begin
      if (cmd.ins_wr) begin
         met_wdata = met_ff;
      end else if (kind_ff == nmt_pkg::KIND_UPD_LL) begin
         met_wdata = {rd_met_ff[95:64], met_ff[63:0]};
      end else begin
         met_wdata = {met_ff[95:64], rd_met_ff[63:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ins_wr) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (cmd.ins_wr || cmd.upd_wr) begin
         met_mem[wr_addr] <= met_wdata;
      end
      rd_key_ff <= key_mem[rd_addr];
      rd_met_ff <= met_mem[rd_addr];
   end

   always_comb begin
      res_status_in = nmt_pkg::ST_MISS;
      res_value_in  = 32'd1;
      res_addr_in   = '0;
      case (cmd.res_code)
         nmt_pkg::RES_OK: begin
            res_status_in = nmt_pkg::ST_OK;
            res_value_in  = 32'd0;
         end
         nmt_pkg::RES_FULL: begin
            res_status_in = nmt_pkg::ST_FULL;
            res_value_in  = 32'd0;
         end
         nmt_pkg::RES_ADDR: begin
            res_status_in = nmt_pkg::ST_OK;
            res_value_in  = 32'd0;
            res_addr_in   = rd_key_ff;
         end
         nmt_pkg::RES_METRIC: begin
            case (sel_ff)
               nmt_pkg::SEL_LATENCY: begin
                  res_status_in = nmt_pkg::ST_OK;
                  res_value_in  = rd_met_ff[31:0];
               end
               nmt_pkg::SEL_LOSS: begin
                  res_status_in = nmt_pkg::ST_OK;
                  res_value_in  = rd_met_ff[63:32];
               end
               nmt_pkg::SEL_THROUGHPUT: begin
                  res_status_in = nmt_pkg::ST_OK;
                  res_value_in  = rd_met_ff[95:64];
               end
               default: begin
                  res_status_in = nmt_pkg::ST_MISS;
                  res_value_in  = 32'd1;
               end
            endcase
         end
         default: begin
            res_status_in = nmt_pkg::ST_MISS;
            res_value_in  = 32'd1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= res_status_in;
         res_value_ff  <= res_value_in;
         res_addr_ff   <= res_addr_in;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   // Stored keys hold addr_high in the low half, so it lands above value.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_data_ff <= {res_addr_ff[127:64], res_addr_ff[63:0], res_value_ff};
         out_user_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

   assign sts.kind      = kind_ff;
   assign sts.full      = (count_ff == CNT_W'(MAX_ENTRIES));
   assign sts.empty     = (count_ff == '0);
   assign sts.pos_ok    = (PCW'(pos_eff) <= PCW'(count_ff));
   assign sts.match     = (rd_key_ff == key_ff);
   assign sts.scan_zero = (scan_ff == '0);
   assign sts.out_free  = !out_valid_ff || rsp_tready;

endmodule

// ===== rtl/nmt_ctrl.sv =====
// Controller of the neighbor metric table: sequences decode, position reads,
// newest-first key scans and result hand-off. Depends on nmt_pkg.
module nmt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  nmt_pkg::sts_type sts,
   output nmt_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECODE = 3'd1;
   localparam logic [2:0] S_READ   = 3'd2;
   localparam logic [2:0] S_SCAN   = 3'd3;
   localparam logic [2:0] S_RESP   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (sts.kind) inside
               nmt_pkg::KIND_INSERT: begin
                  cmd.res_load = 1'b1;
                  state_in     = S_RESP;
                  if (sts.full) begin
                     cmd.res_code = nmt_pkg::RES_FULL;
                  end else begin
                     cmd.ins_wr   = 1'b1;
                     cmd.res_code = nmt_pkg::RES_OK;
                  end
               end
               nmt_pkg::KIND_READ_ADDR, nmt_pkg::KIND_READ_METRIC: begin
                  if (sts.pos_ok) begin
                     state_in = S_READ;
                  end else begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = nmt_pkg::RES_MISS;
                     state_in     = S_RESP;
                  end
               end
               nmt_pkg::KIND_EXISTS, nmt_pkg::KIND_UPD_LL, nmt_pkg::KIND_UPD_THR: begin
                  if (sts.empty) begin
                     cmd.res_load = 1'b1;
                     cmd.res_code = nmt_pkg::RES_MISS;
                     state_in     = S_RESP;
                  end else begin
                     cmd.scan_load = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               default: begin
                  cmd.res_load = 1'b1;
                  cmd.res_code = nmt_pkg::RES_MISS;
                  state_in     = S_RESP;
               end
            endcase
         end
         S_READ: begin
            cmd.res_load = 1'b1;
            cmd.res_code = (sts.kind == nmt_pkg::KIND_READ_ADDR) ?
                           nmt_pkg::RES_ADDR : nmt_pkg::RES_METRIC;
            state_in     = S_RESP;
         end
         S_SCAN: begin
            if (sts.match) begin
               cmd.upd_wr   = (sts.kind != nmt_pkg::KIND_EXISTS);
               cmd.res_load = 1'b1;
               cmd.res_code = nmt_pkg::RES_OK;
               state_in     = S_RESP;
            end else if (sts.scan_zero) begin
               cmd.res_load = 1'b1;
               cmd.res_code = nmt_pkg::RES_MISS;
               state_in     = S_RESP;
            end else begin
               cmd.scan_dec = 1'b1;
            end
         end
         S_RESP: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);

endmodule

// ===== rtl/neighbor_metric_table_core.sv =====
// Top level of the neighbor metric table: joins the controller and datapath.
// Depends on nmt_pkg, nmt_ctrl and nmt_dp.
//
//   Group  Dir  Payload
//   req_   in   tdata: addr_high, addr_low, latency_in, loss_in,
//                      throughput_in, position; tuser: kind, metric_select
//   rsp_   out  tdata: value, addr_out_high, addr_out_low; tuser: status
//
// One transaction is worked at a time. Insert, unused kinds and misses on
// position pass from decode straight to the response state; position reads
// go through one read state first; key lookups scan the entries one at a
// time, newest first, through the single read port of the entry memories.
// A new transaction is accepted while a result waits in the output register.
// Reset empties the table at once; entry contents are not cleared.
module neighbor_metric_table_core #(
   parameter int MAX_ENTRIES = nmt_pkg::MAX_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // addr_high, addr_low, latency_in, loss_in, throughput_in, position
   input  logic [nmt_pkg::REQ_TDATA_W-1:0] req_tdata,
   // kind, metric_select
   input  logic [nmt_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // value, addr_out_high, addr_out_low
   output logic [nmt_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   // status
   output logic [nmt_pkg::RSP_TUSER_W-1:0] rsp_tuser
);

   nmt_pkg::cmd_type cmd;
   nmt_pkg::sts_type sts;

   nmt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   nmt_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for neighbor_metric_table_core: directed table of
// transactions, then random traffic with random idling on both stream sides.
// Depends on nmt_pkg and the RTL of the table core.
`timescale 1ns / 1ps

module tb;

   localparam int TABLE_DEPTH = nmt_pkg::MAX_ENTRIES_DEF;
   localparam int RANDOM_ITEMS = 530;
   localparam int MAX_IDLE = 12;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 2 * TABLE_DEPTH + 8;
   localparam int CYCLE_LIMIT = 200000;

   localparam logic [2:0] KIND_UNUSED_6 = 3'd6;
   localparam logic [2:0] KIND_UNUSED_7 = 3'd7;
   localparam logic [63:0] ONES64 = '1;
   localparam logic [31:0] ONES32 = '1;

   typedef struct packed {
      logic [2:0]  kind;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
      logic [31:0] latency;
      logic [31:0] loss;
      logic [31:0] throughput;
      logic [7:0]  position;
      logic [2:0]  metric_select;
   } table_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
   } table_rsp_type;

   typedef struct {
      table_req_type req;
      bit            typed;
      table_rsp_type rsp;
   } table_row_type;

   localparam table_rsp_type MISS_RSP = '{nmt_pkg::ST_MISS, 32'd1, 64'd0, 64'd0};
   localparam table_rsp_type OK_RSP = '{nmt_pkg::ST_OK, 32'd0, 64'd0, 64'd0};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [nmt_pkg::REQ_TDATA_W-1:0] req_tdata = '0;
   logic [nmt_pkg::REQ_TUSER_W-1:0] req_tuser = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [nmt_pkg::RSP_TDATA_W-1:0] rsp_tdata;
   logic [nmt_pkg::RSP_TUSER_W-1:0] rsp_tuser;

   int            nbr_count;
   logic [127:0]  nbr_key[TABLE_DEPTH];
   logic [31:0]   nbr_latency[TABLE_DEPTH];
   logic [31:0]   nbr_loss[TABLE_DEPTH];
   logic [31:0]   nbr_throughput[TABLE_DEPTH];

   table_rsp_type rsp_expect_q[$];
   table_row_type directed_rows[$];
   logic [127:0]  known_keys[$];
   int            mismatch_count = 0;
   int            accepted_req_count = 0;
   int            rsp_seen_count = 0;
   int            rsp_wait = 0;
   int            cycle_count = 0;
   bit            sender_no_idle = 1'b0;
   logic          rsp_hold = 1'b0;

   neighbor_metric_table_core #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   always #10 clock = ~clock;

   function automatic table_req_type mk_req(input logic [2:0] kind, input logic [63:0] hi,
                                            input logic [63:0] lo, input logic [31:0] lat,
                                            input logic [31:0] loss, input logic [31:0] thr,
                                            input logic [7:0] pos, input logic [2:0] sel);
      table_req_type r;
      r = '{kind, hi, lo, lat, loss, thr, pos, sel};
      return r;
   endfunction

   function automatic int slot_for_position(input logic [7:0] pos);
      int p;
      p = (pos == 8'd0) ? 1 : int'(pos);
      if (p > nbr_count) return -1;
      return nbr_count - p;
   endfunction

   function automatic int newest_slot_for_key(input logic [127:0] key);
      for (int i = nbr_count - 1; i >= 0; i--) begin
         if (nbr_key[i] == key) return i;
      end
      return -1;
   endfunction

   function automatic table_rsp_type predict_table_response(input table_req_type r);
      table_rsp_type res;
      int            slot;
      logic [127:0]  key;
      res = MISS_RSP;
      key = {r.addr_high, r.addr_low};
      case (r.kind)
         nmt_pkg::KIND_INSERT: begin
            res.value = 32'd0;
            if (nbr_count >= TABLE_DEPTH) begin
               res.status = nmt_pkg::ST_FULL;
            end else begin
               nbr_key[nbr_count] = key;
               nbr_latency[nbr_count] = r.latency;
               nbr_loss[nbr_count] = r.loss;
               nbr_throughput[nbr_count] = r.throughput;
               nbr_count++;
               res.status = nmt_pkg::ST_OK;
            end
         end
         nmt_pkg::KIND_READ_ADDR: begin
            slot = slot_for_position(r.position);
            if (slot >= 0) begin
               res = '{nmt_pkg::ST_OK, 32'd0, nbr_key[slot][127:64],
                       nbr_key[slot][63:0]};
            end
         end
         nmt_pkg::KIND_READ_METRIC: begin
            slot = slot_for_position(r.position);
            if (slot >= 0) begin
               case (r.metric_select)
                  nmt_pkg::SEL_LATENCY:
                     res = '{nmt_pkg::ST_OK, nbr_latency[slot], 64'd0, 64'd0};
                  nmt_pkg::SEL_LOSS:
                     res = '{nmt_pkg::ST_OK, nbr_loss[slot], 64'd0, 64'd0};
                  nmt_pkg::SEL_THROUGHPUT:
                     res = '{nmt_pkg::ST_OK, nbr_throughput[slot], 64'd0, 64'd0};
                  default: res = MISS_RSP;
               endcase
            end
         end
         nmt_pkg::KIND_EXISTS: begin
            if (newest_slot_for_key(key) >= 0) res = OK_RSP;
         end
         nmt_pkg::KIND_UPD_LL: begin
            slot = newest_slot_for_key(key);
            if (slot >= 0) begin
               nbr_latency[slot] = r.latency;
               nbr_loss[slot] = r.loss;
               res = OK_RSP;
            end
         end
         nmt_pkg::KIND_UPD_THR: begin
            slot = newest_slot_for_key(key);
            if (slot >= 0) begin
               nbr_throughput[slot] = r.throughput;
               res = OK_RSP;
            end
         end
         default: res = MISS_RSP;
      endcase
      return res;
   endfunction

   task automatic drive_request(input table_req_type r, input bit typed,
                                input table_rsp_type want);
      int unsigned   gap;
      table_rsp_type predicted;
      gap = sender_no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {r.position, r.throughput, r.loss, r.latency, r.addr_low, r.addr_high};
      req_tuser <= {r.metric_select, r.kind};
      do @(posedge clock); while (!req_tready);
      predicted = predict_table_response(r);
      rsp_expect_q.push_back(typed ? want : predicted);
      if (r.kind == nmt_pkg::KIND_INSERT) known_keys.push_back({r.addr_high, r.addr_low});
      accepted_req_count++;
   endtask

   task automatic check_response(input table_rsp_type got);
      table_rsp_type want;
      if (rsp_expect_q.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Unexpected transaction: status %0d value %h addr %h_%h",
                     got.status, got.value, got.addr_hi, got.addr_lo);
      end else begin
         want = rsp_expect_q.pop_front();
         if (got.status !== want.status || got.value !== want.value ||
             got.addr_hi !== want.addr_hi || got.addr_lo !== want.addr_lo) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("Mismatch at %0t: expected %0d %h %h_%h, got %0d %h %h_%h",
                        $realtime, want.status, want.value, want.addr_hi, want.addr_lo,
                        got.status, got.value, got.addr_hi, got.addr_lo);
         end
      end
   endtask

   always @(posedge clock) begin
      int unsigned next_wait;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_wait <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         check_response('{rsp_tuser[1:0], rsp_tdata[31:0], rsp_tdata[95:32], rsp_tdata[159:96]});
         rsp_seen_count++;
         next_wait = (((rsp_seen_count / 50) % 3) == 1) ? 0 : $urandom_range(0, MAX_IDLE);
         rsp_wait <= next_wait;
         rsp_tready <= (next_wait == 0) && !rsp_hold;
      end else if (rsp_wait != 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_tready <= (rsp_wait == 1) && !rsp_hold;
      end else begin
         rsp_tready <= !rsp_hold;
      end
   end

   initial begin
      wait (accepted_req_count >= 120);
      @(posedge clock);
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      table_req_type r;
      table_row_type row;
      logic [127:0]  key;
      int unsigned   pick;
      nbr_count = 0;

      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_ADDR, 0, 0, 0, 0, 0, 8'd1, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd0,
                                       nmt_pkg::SEL_LATENCY), 1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_EXISTS, ONES64, ONES64, 0, 0, 0, 0, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_UPD_LL, 0, 0, 32'd5, 32'd6, 0, 0, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_UPD_THR, ONES64, ONES64, 0, 0, 32'd7,
                                       0, 0), 1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(KIND_UNUSED_6, 0, 0, 0, 0, 0, 0, 0), 1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(KIND_UNUSED_7, ONES64, ONES64, ONES32, ONES32, ONES32,
                                       8'hff, 3'd7), 1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_INSERT, ONES64, ONES64, ONES32, ONES32,
                                       ONES32, 8'hff, 3'd7), 1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_INSERT, 0, 0, 0, 0, 0, 0, 0),
                                1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_INSERT, 64'h0123_4567_89ab_cdef,
                                       64'hfedc_ba98_7654_3210, 32'h0000_1234, 32'h8000_0001,
                                       32'h5a5a_a5a5, 8'd0, 0), 1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_ADDR, 0, 0, 0, 0, 0, 8'd0, 0),
                                1'b0, '0});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_ADDR, 0, 0, 0, 0, 0, 8'd3, 0),
                                1'b1, '{nmt_pkg::ST_OK, 32'd0, ONES64, ONES64}});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_ADDR, 0, 0, 0, 0, 0, 8'd4, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_ADDR, 0, 0, 0, 0, 0, 8'hff, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd3,
                                       nmt_pkg::SEL_LATENCY), 1'b1,
                                '{nmt_pkg::ST_OK, ONES32, 64'd0, 64'd0}});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd2,
                                       nmt_pkg::SEL_LOSS), 1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd1,
                                       nmt_pkg::SEL_THROUGHPUT), 1'b0, '0});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd1, 3'd0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd3, 3'd7),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd4,
                                       nmt_pkg::SEL_LATENCY), 1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_EXISTS, 0, 0, 0, 0, 0, 0, 0),
                                1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_EXISTS, ONES64, 0, 0, 0, 0, 0, 0),
                                1'b1, MISS_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_INSERT, ONES64, ONES64, 32'd7, 32'd9,
                                       32'd11, 0, 0), 1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_UPD_LL, ONES64, ONES64, 32'hdead_beef,
                                       32'd3, 0, 0, 0), 1'b1, OK_RSP});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd1,
                                       nmt_pkg::SEL_LATENCY), 1'b0, '0});
      directed_rows.push_back('{mk_req(nmt_pkg::KIND_READ_METRIC, 0, 0, 0, 0, 0, 8'd4,
                                       nmt_pkg::SEL_LATENCY), 1'b0, '0});

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         drive_request(row.req, row.typed, row.rsp);
      end

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         sender_no_idle = ((n / 64) % 3) == 2;
         pick = $urandom_range(0, 99);
         if (pick < 9) r.kind = nmt_pkg::KIND_INSERT;
         else if (pick < 24) r.kind = nmt_pkg::KIND_READ_ADDR;
         else if (pick < 44) r.kind = nmt_pkg::KIND_READ_METRIC;
         else if (pick < 62) r.kind = nmt_pkg::KIND_EXISTS;
         else if (pick < 80) r.kind = nmt_pkg::KIND_UPD_LL;
         else if (pick < 97) r.kind = nmt_pkg::KIND_UPD_THR;
         else r.kind = $urandom_range(0, 1) ? KIND_UNUSED_6 : KIND_UNUSED_7;

         pick = $urandom_range(0, 99);
         if (known_keys.size() != 0 && pick < 70)
            key = known_keys[$urandom_range(0, known_keys.size() - 1)];
         else if (known_keys.size() != 0 && pick < 85)
            key = known_keys[$urandom_range(0, known_keys.size() - 1)]
                  ^ (128'd1 << $urandom_range(0, 127));
         else
            key = {$urandom, $urandom, $urandom, $urandom};
         if (r.kind == nmt_pkg::KIND_INSERT && $urandom_range(0, 4) != 0)
            key = {$urandom, $urandom, $urandom, $urandom};
         r.addr_high = key[127:64];
         r.addr_low = key[63:0];

         r.latency = $urandom;
         r.loss = $urandom;
         r.throughput = $urandom;
         if ($urandom_range(0, 99) < 70) r.position = 8'($urandom_range(0, nbr_count + 1));
         else r.position = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 4) != 0) r.metric_select = 3'($urandom_range(2, 4));
         else r.metric_select = 3'($urandom_range(0, 7));

         drive_request(r, 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (rsp_expect_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/nmt_pkg.sv
rtl/nmt_dp.sv
rtl/nmt_ctrl.sv
rtl/neighbor_metric_table_core.sv
tb/tb.sv
